### src/mcv_pkg.sv
package mcv_pkg;

   localparam int MAX_LEN   = 4096;
   localparam int FRAC_BITS = 16;
   localparam int CNT_W     = 13;
   localparam int VAL_W     = 17;
   localparam int CSR_IDX_W = 2;

   // Z rounded to 24 fraction bits
   localparam logic [25:0] ZQ24 = 26'd43215245;

   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;
   localparam int LOG_STEPS  = FRAC_BITS;
   localparam int STEP_W     = 6;

   localparam logic [VAL_W-1:0] ONE_BIT = VAL_W'(1 << FRAC_BITS);

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_LIMIT    = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV1,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_MUL,
      ST_DIV2_INIT,
      ST_DIV2,
      ST_CHECK,
      ST_LOG_SQ,
      ST_LOG_ST,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TAKE,
      OP_DIV1_INIT,
      OP_DIV_STEP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_MUL,
      OP_DIV2_INIT,
      OP_LOG_INIT,
      OP_LOG_SQ,
      OP_LOG_ST,
      OP_FINISH,
      OP_ZERO,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic n_is_one;
      logic quo_big;
      logic out_free;
   } dp_status_type;

endpackage

### src/mcv_ctrl.sv
module mcv_ctrl
   import mcv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   input  logic          req_last_bit,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = '0;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_TAKE;
               if (!req_command && req_last_bit) state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.n_is_one) begin
               cmd.op   = OP_ZERO;
               state_in = ST_OUT;
            end else begin
               cmd.op   = OP_DIV1_INIT;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_SQRT_INIT;
         end
         ST_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op  = OP_SQRT_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_DIV2_INIT;
         end
         ST_DIV2_INIT: begin
            cmd.op   = OP_DIV2_INIT;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.quo_big) begin
               cmd.op   = OP_ZERO;
               state_in = ST_OUT;
            end else begin
               cmd.op   = OP_LOG_INIT;
               state_in = ST_LOG_SQ;
            end
         end
         ST_LOG_SQ: begin
            cmd.op   = OP_LOG_SQ;
            step_in  = step_ff;
            state_in = ST_LOG_ST;
         end
         ST_LOG_ST: begin
            cmd.op  = OP_LOG_ST;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(LOG_STEPS - 1)) state_in = ST_FINISH;
            else state_in = ST_LOG_SQ;
         end
         ST_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/mcv_dp.sv
module mcv_dp
   import mcv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic                 req_command,
   input  logic                 req_sample_bit,
   input  logic                 req_last_bit,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_seq_entropy,
   output logic [VAL_W-1:0]     rsp_running_min,
   output logic [CNT_W-1:0]     rsp_ones_seen,
   output logic [CNT_W-1:0]     rsp_seq_length,
   output logic                 rsp_below_threshold,
   output logic                 rsp_meets_limit,
   output logic                 rsp_length_overflow
);

   logic [VAL_W-1:0] thr_ff, lim_ff, min_ff;
   logic [CNT_W-1:0] ones_cnt_ff, len_cnt_ff;
   logic             ovf_cnt_ff;
   logic [CNT_W-1:0] ones_snap_ff, n_snap_ff;
   logic             ovf_snap_ff;

   logic [63:0]      dvd_ff, quo_ff;
   logic [CNT_W:0]   rem_ff;
   logic [CNT_W-1:0] dsr_ff;
   logic [63:0]      sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [63:0]      t_ff;
   logic [31:0]      y_ff;
   logic [63:0]      prod_ff;
   logic [FRAC_BITS-1:0] lg_ff;
   logic [VAL_W-1:0] ent_ff;

   logic             rsp_valid_ff;
   logic [VAL_W-1:0] out_ent_ff, out_min_ff;
   logic [CNT_W-1:0] out_ones_ff, out_len_ff;
   logic             out_below_ff, out_meets_ff, out_ovf_ff;

   // sample counting
   logic             at_max;
   logic [CNT_W-1:0] len_new, ones_new;
   logic             ovf_new;

   // estimate setup
   logic [CNT_W-1:0] n_minus_ones, k_val, n_minus_k;
   logic [2*CNT_W-1:0] kk;

   // divider step
   logic [CNT_W+1:0] rem_shift;
   logic             rem_ge;

   // sqrt step
   logic [63:0]      sq_trial;
   logic             sq_ge;

   // log step
   logic [32:0]      y_sq;

   logic [VAL_W-1:0] min_new;

   assign at_max   = len_cnt_ff >= CNT_W'(MAX_LEN);
   assign len_new  = at_max ? len_cnt_ff : len_cnt_ff + 1'b1;
   assign ones_new = at_max ? ones_cnt_ff : ones_cnt_ff + CNT_W'(req_sample_bit);
   assign ovf_new  = ovf_cnt_ff | at_max;

   assign n_minus_ones = n_snap_ff - ones_snap_ff;
   assign k_val        = (ones_snap_ff > n_minus_ones) ? ones_snap_ff : n_minus_ones;
   assign n_minus_k    = n_snap_ff - k_val;
   assign kk           = k_val * n_minus_k;

   assign rem_shift = {rem_ff, dvd_ff[63]};
   assign rem_ge    = rem_shift >= {2'b00, dsr_ff};

   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign sq_ge    = sq_v_ff >= sq_trial;

   assign y_sq = prod_ff[63:31];

   assign min_new = (ent_ff < min_ff) ? ent_ff : min_ff;

   assign status.n_is_one = n_snap_ff == CNT_W'(1);
   assign status.quo_big  = quo_ff[63:32] != '0;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= VAL_W'(32768);
         lim_ff       <= '0;
         min_ff       <= ONE_BIT;
         ones_cnt_ff  <= '0;
         len_cnt_ff   <= '0;
         ovf_cnt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_LOW_THRESHOLD: thr_ff <= csr_wdata;
               CSR_PASS_LIMIT:    lim_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.op == OP_TAKE) begin
            if (req_command) begin
               ones_cnt_ff <= '0;
               len_cnt_ff  <= '0;
               ovf_cnt_ff  <= 1'b0;
               min_ff      <= ONE_BIT;
            end else if (req_last_bit) begin
               ones_cnt_ff <= '0;
               len_cnt_ff  <= '0;
               ovf_cnt_ff  <= 1'b0;
            end else begin
               ones_cnt_ff <= ones_new;
               len_cnt_ff  <= len_new;
               ovf_cnt_ff  <= ovf_new;
            end
         end
         if (cmd.op == OP_PUBLISH) begin
            min_ff       <= min_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // arithmetic and result payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_TAKE: begin
            ones_snap_ff <= ones_new;
            n_snap_ff    <= len_new;
            ovf_snap_ff  <= ovf_new;
         end
         OP_DIV1_INIT: begin
            dvd_ff <= 64'(kk) << 32;
            dsr_ff <= n_snap_ff - 1'b1;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            quo_ff <= {quo_ff[62:0], rem_ge};
            rem_ff <= rem_ge ? (CNT_W+1)'(rem_shift - {2'b00, dsr_ff})
                             : rem_shift[CNT_W:0];
         end
         OP_SQRT_INIT: begin
            sq_v_ff   <= quo_ff;
            sq_res_ff <= '0;
            sq_bit_ff <= 64'd1 << 62;
         end
         OP_SQRT_STEP: begin
            if (sq_ge) begin
               sq_v_ff   <= sq_v_ff - sq_trial;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_MUL: begin
            t_ff <= (64'(ZQ24) * 64'(sq_res_ff[31:0])) >> 8;
         end
         OP_DIV2_INIT: begin
            dvd_ff <= (64'(k_val) << 32) + t_ff;
            dsr_ff <= n_snap_ff;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         OP_LOG_INIT: begin
            y_ff  <= quo_ff[31:0];
            lg_ff <= '0;
         end
         OP_LOG_SQ: begin
            prod_ff <= 64'(y_ff) * 64'(y_ff);
         end
         OP_LOG_ST: begin
            lg_ff <= {lg_ff[FRAC_BITS-2:0], y_sq[32]};
            y_ff  <= y_sq[32] ? y_sq[32:1] : y_sq[31:0];
         end
         OP_FINISH: begin
            ent_ff <= ONE_BIT - VAL_W'(lg_ff);
         end
         OP_ZERO: begin
            ent_ff <= '0;
         end
         OP_PUBLISH: begin
            out_ent_ff   <= ent_ff;
            out_min_ff   <= min_new;
            out_ones_ff  <= ones_snap_ff;
            out_len_ff   <= n_snap_ff;
            out_below_ff <= ent_ff < thr_ff;
            out_meets_ff <= min_new >= lim_ff;
            out_ovf_ff   <= ovf_snap_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_seq_entropy     = out_ent_ff;
   assign rsp_running_min     = out_min_ff;
   assign rsp_ones_seen       = out_ones_ff;
   assign rsp_seq_length      = out_len_ff;
   assign rsp_below_threshold = out_below_ff;
   assign rsp_meets_limit     = out_meets_ff;
   assign rsp_length_overflow = out_ovf_ff;

endmodule

### src/mcv_min_entropy_estimator.sv
// channel | handshake            | payload
// req     | req_valid/req_ready  | req_command, req_sample_bit, req_last_bit
// rsp     | rsp_valid/rsp_ready  | rsp_seq_entropy .. rsp_length_overflow
// csr     | csr_valid/csr_ready  | csr_index, csr_wdata (csr_ready always high)
//
// Sample and clear items are taken in the idle state and do not leave it.
// An item that ends a sequence runs two 64-step restoring divides and a
// 32-step square root on one shared datapath, then 16 square-and-shift
// log steps; a length-one sequence skips these and gives a zero estimate.
// Reset is synchronous; only control, counter, CSR and minimum registers
// take default values. The result register holds a finished item while
// new samples are taken; a following sequence end waits until it is free.
module mcv_min_entropy_estimator
   import mcv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic                 req_sample_bit,
   input  logic                 req_last_bit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_seq_entropy,
   output logic [VAL_W-1:0]     rsp_running_min,
   output logic [CNT_W-1:0]     rsp_ones_seen,
   output logic [CNT_W-1:0]     rsp_seq_length,
   output logic                 rsp_below_threshold,
   output logic                 rsp_meets_limit,
   output logic                 rsp_length_overflow,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mcv_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_command  (req_command),
      .req_last_bit (req_last_bit),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   mcv_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_command),
      .req_sample_bit      (req_sample_bit),
      .req_last_bit        (req_last_bit),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_seq_entropy     (rsp_seq_entropy),
      .rsp_running_min     (rsp_running_min),
      .rsp_ones_seen       (rsp_ones_seen),
      .rsp_seq_length      (rsp_seq_length),
      .rsp_below_threshold (rsp_below_threshold),
      .rsp_meets_limit     (rsp_meets_limit),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

### src/mcv_checker.sv
module mcv_checker
   import mcv_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [VAL_W-1:0] rsp_seq_entropy,
   input logic [VAL_W-1:0] rsp_running_min,
   input logic [CNT_W-1:0] rsp_ones_seen,
   input logic [CNT_W-1:0] rsp_seq_length,
   input logic             rsp_length_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped before accept");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seq_length != '0)
      else $error("empty sequence reported");

   a_min_le_ent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_min <= rsp_seq_entropy)
      else $error("running minimum above sequence estimate");

   a_ones_le_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ones_seen <= rsp_seq_length)
      else $error("ones count exceeds length");

   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_overflow |-> rsp_seq_length == CNT_W'(MAX_LEN))
      else $error("overflow without saturated length");

endmodule

bind mcv_min_entropy_estimator mcv_checker u_mcv_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_seq_entropy     (rsp_seq_entropy),
   .rsp_running_min     (rsp_running_min),
   .rsp_ones_seen       (rsp_ones_seen),
   .rsp_seq_length      (rsp_seq_length),
   .rsp_length_overflow (rsp_length_overflow)
);

### tb/sv/mcv_min_entropy_estimator_tb.sv
module mcv_min_entropy_estimator_tb;
   import mcv_pkg::*;

   typedef struct {
      logic command;
      logic sample_bit;
      logic last_bit;
   } sample_item_type;

   typedef struct packed {
      logic [VAL_W-1:0] seq_entropy;
      logic [VAL_W-1:0] running_min;
      logic [CNT_W-1:0] ones_seen;
      logic [CNT_W-1:0] seq_length;
      logic             below_threshold;
      logic             meets_limit;
      logic             length_overflow;
   } estimate_type;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_command = 1'b0;
   logic                 req_sample_bit = 1'b0;
   logic                 req_last_bit = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [VAL_W-1:0]     rsp_seq_entropy;
   logic [VAL_W-1:0]     rsp_running_min;
   logic [CNT_W-1:0]     rsp_ones_seen;
   logic [CNT_W-1:0]     rsp_seq_length;
   logic                 rsp_below_threshold;
   logic                 rsp_meets_limit;
   logic                 rsp_length_overflow;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0]     csr_wdata = '0;

   mcv_min_entropy_estimator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [VAL_W-1:0] low_threshold_q;
   logic [VAL_W-1:0] pass_limit_q;
   int unsigned      ones_cnt;
   int unsigned      len_cnt;
   logic             overflow_q;
   logic [VAL_W-1:0] run_min_q;

   sample_item_type pending_q[$];
   estimate_type    want_q[$];
   int           mismatches = 0;
   int           cycles = 0;
   bit           quiet = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic [VAL_W-1:0] mcv_entropy(longint unsigned ones,
                                                     longint unsigned n);
      longint unsigned k, q, s, t, x, y, lg, val;
      if (n <= 1) return '0;
      k = (ones > n - ones) ? ones : n - ones;
      q = ((k * (n - k)) << 32) / (n - 1);
      s = int_sqrt(q);
      t = (64'(ZQ24) * s) >> 8;
      x = ((k << 32) + t) / n;
      if (x >= (64'd1 << 32)) return '0;
      y = x;
      lg = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         y = (y * y) >> 31;
         lg = lg << 1;
         if (y >= (64'd1 << 32)) begin
            lg = lg | 1;
            y = y >> 1;
         end
      end
      val = (64'd1 << FRAC_BITS) - lg;
      return (val > 64'h1FFFF) ? 17'h1FFFF : val[VAL_W-1:0];
   endfunction

   task automatic clear_estimator();
      ones_cnt = 0;
      len_cnt = 0;
      overflow_q = 1'b0;
      run_min_q = ONE_BIT;
   endtask

   task automatic mcv_predict(sample_item_type it);
      estimate_type e;
      if (it.command) begin
         clear_estimator();
         return;
      end
      if (len_cnt >= MAX_LEN) begin
         overflow_q = 1'b1;
      end else begin
         len_cnt++;
         ones_cnt += it.sample_bit;
      end
      if (!it.last_bit) return;
      e.seq_entropy = mcv_entropy(ones_cnt, len_cnt);
      if (e.seq_entropy < run_min_q) run_min_q = e.seq_entropy;
      e.running_min = run_min_q;
      e.ones_seen = CNT_W'(ones_cnt);
      e.seq_length = CNT_W'(len_cnt);
      e.below_threshold = e.seq_entropy < low_threshold_q;
      e.meets_limit = run_min_q >= pass_limit_q;
      e.length_overflow = overflow_q;
      want_q.push_back(e);
      ones_cnt = 0;
      len_cnt = 0;
      overflow_q = 1'b0;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      sample_item_type nxt;
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            nxt.command = req_command;
            nxt.sample_bit = req_sample_bit;
            nxt.last_bit = req_last_bit;
            mcv_predict(nxt);
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               req_command <= nxt.command;
               req_sample_bit <= nxt.sample_bit;
               req_last_bit <= nxt.last_bit;
               nv = 1'b1;
               send_gap = gap_len();
            end
         end
         req_valid <= nv;
      end
   end

   // monitor
   int recv_stall = 0;
   always @(posedge clock) begin
      estimate_type got, exp_e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_seq_entropy, rsp_running_min, rsp_ones_seen, rsp_seq_length,
                   rsp_below_threshold, rsp_meets_limit, rsp_length_overflow};
            if (want_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: ent=%0d min=%0d", got.seq_entropy,
                           got.running_min);
            end else begin
               exp_e = want_q.pop_front();
               if (got != exp_e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp ent=%0d min=%0d ones=%0d len=%0d lo=%0b ",
                               "ok=%0b ovf=%0b / got ent=%0d min=%0d ones=%0d len=%0d ",
                               "lo=%0b ok=%0b ovf=%0b"},
                              exp_e.seq_entropy, exp_e.running_min, exp_e.ones_seen,
                              exp_e.seq_length, exp_e.below_threshold,
                              exp_e.meets_limit, exp_e.length_overflow,
                              got.seq_entropy, got.running_min, got.ones_seen,
                              got.seq_length, got.below_threshold, got.meets_limit,
                              got.length_overflow);
               end
            end
            recv_stall = gap_len();
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic add_item(logic c, logic b, logic l);
      sample_item_type it;
      it.command = c;
      it.sample_bit = b;
      it.last_bit = l;
      pending_q.push_back(it);
   endtask

   // sequence of len samples, ones with probability pct percent
   task automatic add_seq(int len, int pct, bit close = 1);
      for (int i = 0; i < len; i++)
         add_item(1'b0, $urandom_range(0, 99) < pct, close && (i == len - 1));
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_q.size() > 0 || req_valid || want_q.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LOW_THRESHOLD) low_threshold_q = data;
      else if (idx == CSR_PASS_LIMIT) pass_limit_q = data;
      @(posedge clock);
   endtask

   task automatic random_phase(int n_items);
      int start, len, pct, r;
      start = pending_q.size();
      while (pending_q.size() - start < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 70) len = $urandom_range(1, 16);
         else if (r < 95) len = $urandom_range(17, 120);
         else len = $urandom_range(121, 400);
         case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 100;
            2: pct = 50;
            default: pct = $urandom_range(0, 100);
         endcase
         r = $urandom_range(0, 99);
         if (r < 8) begin
            add_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (r < 13) begin
            // sequence broken off by a clear
            add_seq(len, pct, 0);
            add_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            add_seq(len, pct);
         end
      end
   endtask

   initial begin
      logic [VAL_W-1:0] thr, lim;
      low_threshold_q = 17'd32768;
      pass_limit_q = '0;
      clear_estimator();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: length one, tiny sequences, all ones, alternating, clear
      add_seq(1, 0);
      add_seq(1, 100);
      add_item(1'b0, 1'b0, 1'b0);
      add_item(1'b0, 1'b1, 1'b1);
      add_seq(2, 100);
      add_item(1'b1, 1'b1, 1'b1);
      add_seq(8, 100);
      for (int i = 0; i < 8; i++) add_item(1'b0, i[0], i == 7);
      add_item(1'b0, 1'b1, 1'b0);
      add_item(1'b0, 1'b1, 1'b0);
      add_item(1'b0, 1'b0, 1'b1);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin thr = '0;          lim = '0;          end
            1: begin thr = 17'd65536;   lim = 17'd65536;   end
            2: begin thr = 17'd40000;   lim = 17'd20000;   end
            3: begin thr = 17'h1FFFF;   lim = 17'd1;       end
            default: begin
               thr = VAL_W'($urandom_range(0, 65536));
               lim = VAL_W'($urandom_range(0, 65536));
            end
         endcase
         csr_write(CSR_LOW_THRESHOLD, thr);
         csr_write(CSR_PASS_LIMIT, lim);
         csr_write(CSR_IDX_W'($urandom_range(2, 3)), VAL_W'($urandom_range(0, 17'h1FFFF)));
         quiet = (ph == 2);
         random_phase(270);
         wait_idle();
      end

      if (mismatches == 0 && want_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
